/* rtl/l2c_pkg.sv */
`default_nettype none

package l2c_pkg;

    // Result queue sizing
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W      = $clog2(MAX_RES + 1);

    localparam int CHAR_W = 16;
    localparam int CODE_W = 11;

    // Cyrillic code points
    localparam logic [CODE_W-1:0] CY_NONE  = 11'h000;
    localparam logic [CODE_W-1:0] CY_SPACE = 11'h020;
    localparam logic [CODE_W-1:0] CY_A     = 11'h430;
    localparam logic [CODE_W-1:0] CY_BE    = 11'h431;
    localparam logic [CODE_W-1:0] CY_VE    = 11'h432;
    localparam logic [CODE_W-1:0] CY_GHE   = 11'h433;
    localparam logic [CODE_W-1:0] CY_DE    = 11'h434;
    localparam logic [CODE_W-1:0] CY_IE    = 11'h435;
    localparam logic [CODE_W-1:0] CY_ZHE   = 11'h436;
    localparam logic [CODE_W-1:0] CY_ZE    = 11'h437;
    localparam logic [CODE_W-1:0] CY_I     = 11'h438;
    localparam logic [CODE_W-1:0] CY_SHORT = 11'h439;
    localparam logic [CODE_W-1:0] CY_KA    = 11'h43A;
    localparam logic [CODE_W-1:0] CY_EL    = 11'h43B;
    localparam logic [CODE_W-1:0] CY_EM    = 11'h43C;
    localparam logic [CODE_W-1:0] CY_EN    = 11'h43D;
    localparam logic [CODE_W-1:0] CY_O     = 11'h43E;
    localparam logic [CODE_W-1:0] CY_PE    = 11'h43F;
    localparam logic [CODE_W-1:0] CY_ER    = 11'h440;
    localparam logic [CODE_W-1:0] CY_ES    = 11'h441;
    localparam logic [CODE_W-1:0] CY_TE    = 11'h442;
    localparam logic [CODE_W-1:0] CY_U     = 11'h443;
    localparam logic [CODE_W-1:0] CY_EF    = 11'h444;
    localparam logic [CODE_W-1:0] CY_HA    = 11'h445;
    localparam logic [CODE_W-1:0] CY_TSE   = 11'h446;
    localparam logic [CODE_W-1:0] CY_CHE   = 11'h447;
    localparam logic [CODE_W-1:0] CY_SHA   = 11'h448;
    localparam logic [CODE_W-1:0] CY_SHCHA = 11'h449;
    localparam logic [CODE_W-1:0] CY_HARD  = 11'h44A;
    localparam logic [CODE_W-1:0] CY_YERU  = 11'h44B;
    localparam logic [CODE_W-1:0] CY_SOFT  = 11'h44C;
    localparam logic [CODE_W-1:0] CY_E     = 11'h44D;
    localparam logic [CODE_W-1:0] CY_YU    = 11'h44E;
    localparam logic [CODE_W-1:0] CY_YA    = 11'h44F;
    localparam logic [CODE_W-1:0] CY_YO    = 11'h451;

    // Pending multi-letter prefix
    typedef enum logic [3:0] {
        P_NONE = 4'd0,
        P_Z    = 4'd1,
        P_K    = 4'd2,
        P_T    = 4'd3,
        P_C    = 4'd4,
        P_J    = 4'd5,
        P_Y    = 4'd6,
        P_S    = 4'd7,
        P_SH   = 4'd8,
        P_SHC  = 4'd9
    } prefix_t;

    // One queued result
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              err;
        logic              eor;
    } res_t;

    // Letter for a character standing alone, CY_NONE if it has none
    function automatic logic [CODE_W-1:0] lone_letter(input logic [CHAR_W-1:0] x);
        case (x)
            16'("a"): return CY_A;
            16'("b"): return CY_BE;
            16'("v"): return CY_VE;
            16'("g"): return CY_GHE;
            16'("d"): return CY_DE;
            16'("e"): return CY_IE;
            16'("i"): return CY_I;
            16'("l"): return CY_EL;
            16'("m"): return CY_EM;
            16'("n"): return CY_EN;
            16'("o"): return CY_O;
            16'("p"): return CY_PE;
            16'("r"): return CY_ER;
            16'("u"): return CY_U;
            16'("f"): return CY_EF;
            16'("h"): return CY_HA;
            16'("x"): return CY_HA;
            16'("w"): return CY_SHCHA;
            16'("#"): return CY_HARD;
            16'("'"): return CY_SOFT;
            default:  return CY_NONE;
        endcase
    endfunction

    // Prefix opened by a character
    function automatic prefix_t starts_prefix(input logic [CHAR_W-1:0] x);
        case (x)
            16'("z"): return P_Z;
            16'("k"): return P_K;
            16'("t"): return P_T;
            16'("c"): return P_C;
            16'("j"): return P_J;
            16'("y"): return P_Y;
            16'("s"): return P_S;
            default:  return P_NONE;
        endcase
    endfunction

    // Letter made by joining x onto prefix p, CY_NONE if no join
    function automatic logic [CODE_W-1:0] join_letter(input prefix_t p,
                                                      input logic [CHAR_W-1:0] x);
        logic [CODE_W-1:0] r;
        r = CY_NONE;
        case (p)
            P_Z:   if (x == 16'("h")) r = CY_ZHE;
            P_K:   if (x == 16'("h")) r = CY_HA;
            P_T:   if (x == 16'("s")) r = CY_TSE;
            P_C:   if (x == 16'("h")) r = CY_CHE;
            P_J: begin
                if      (x == 16'("o")) r = CY_YO;
                else if (x == 16'("e")) r = CY_E;
                else if (x == 16'("u")) r = CY_YU;
                else if (x == 16'("a")) r = CY_YA;
            end
            P_Y: begin
                if      (x == 16'("u")) r = CY_YU;
                else if (x == 16'("a")) r = CY_YA;
                else if (x == 16'("o")) r = CY_YO;
            end
            P_SHC: if (x == 16'("h")) r = CY_SHCHA;
            default: r = CY_NONE;
        endcase
        return r;
    endfunction

    // Longer prefix made by x (s -> sh -> shc)
    function automatic prefix_t join_prefix(input prefix_t p, input logic [CHAR_W-1:0] x);
        prefix_t r;
        r = P_NONE;
        case (p)
            P_S:     if (x == 16'("h")) r = P_SH;
            P_SH:    if (x == 16'("c")) r = P_SHC;
            default: r = P_NONE;
        endcase
        return r;
    endfunction

    // First letter a prefix spells alone; shc adds tse after it
    function automatic logic [CODE_W-1:0] flush_letter(input prefix_t p);
        case (p)
            P_Z:     return CY_ZE;
            P_K:     return CY_KA;
            P_T:     return CY_TE;
            P_C:     return CY_TSE;
            P_J:     return CY_SHORT;
            P_Y:     return CY_YERU;
            P_S:     return CY_ES;
            P_SH:    return CY_SHA;
            P_SHC:   return CY_SHA;
            default: return CY_NONE;
        endcase
    endfunction

endpackage

`default_nettype wire

/* rtl/latin_to_cyrillic_transliterator.sv */
`default_nettype none

// Lower-case Latin to Cyrillic transliterator. One 16-bit character is
// accepted per cycle on the s_ stream (tlast marks the end of a string);
// Cyrillic letters leave on the m_ stream, one per cycle while m_tready is
// high, with tlast on the last result of the string and tuser set on the
// single error result that ends a failed string. Multi-letter spellings
// (zh, kh, ts, ch, sh, shch, jo/je/ju/ja, yu/ya/yo) are held as a pending
// prefix and resolved by the next character or by the end of the string.
// A character gives zero to three results; the one-pass translation stage
// feeds a four-entry result queue and stalls the input only while the
// queue lacks room for three results, so one character is taken per cycle
// while the queue, after that cycle's read, holds at most one result. A
// character passes through the input register and then the result queue
// before its first result appears. cfg_data (written with cfg_valid,
// always ready) selects whether an unexpected character becomes a space (1,
// reset value) or an error (0); write it only while the block is idle.
module latin_to_cyrillic_transliterator
    import l2c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,     // unexpected_as_space

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,      // [15:0] char_code
    input  wire logic        s_tlast,      // end_of_string

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // [10:0] cyrillic_code, [15:11] zero
    output logic [0:0]       m_tuser,      // [0] error
    output logic             m_tlast       // end_of_run
);

    logic                    mode_space_reg;

    logic                    in_valid_reg;
    logic [CHAR_W-1:0]       in_code_reg;
    logic                    in_eos_reg;

    prefix_t                 pend_reg, pend_next;
    logic                    disc_reg, disc_next;

    res_t                    fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_after_pop;

    logic                    fire;
    logic                    pop;

    logic [CODE_W-1:0]       step_code [MAX_RES];
    logic [RES_W-1:0]        step_cnt;
    logic                    step_err;
    logic [CODE_W-1:0]       lone;
    prefix_t                 start_p;
    logic [CODE_W-1:0]       jl;
    prefix_t                 jp;
    prefix_t                 trail;

    // Handshakes
    assign cfg_ready       = 1'b1;
    assign pop             = m_tvalid && m_tready;
    assign count_after_pop = count_reg - CNT_W'(pop);
    assign fire            = in_valid_reg
                             && (count_after_pop <= CNT_W'(FIFO_DEPTH - MAX_RES));
    assign s_tready        = !in_valid_reg || fire;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_space_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            mode_space_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    // Translation of the registered character
    always_comb begin
        lone      = lone_letter(in_code_reg);
        start_p   = starts_prefix(in_code_reg);
        jl        = join_letter(pend_reg, in_code_reg);
        jp        = join_prefix(pend_reg, in_code_reg);
        step_code = '{default: CY_NONE};
        step_cnt  = '0;
        step_err  = 1'b0;
        trail     = P_NONE;
        pend_next = pend_reg;
        disc_next = disc_reg;

        if (fire) begin
            if (disc_reg) begin
                // swallow the rest of a failed string
                if (in_eos_reg) begin
                    disc_next = 1'b0;
                    pend_next = P_NONE;
                end
            end else if (jl == CY_NONE && jp == P_NONE && lone == CY_NONE
                         && start_p == P_NONE && !mode_space_reg) begin
                // unexpected character: single error result
                step_cnt  = RES_W'(1);
                step_err  = 1'b1;
                pend_next = P_NONE;
                disc_next = !in_eos_reg;
            end else begin
                if (jl != CY_NONE) begin
                    step_code[0] = jl;
                    step_cnt     = RES_W'(1);
                end else if (jp != P_NONE) begin
                    trail = jp;
                end else begin
                    // flush the old prefix, then the character itself
                    if (flush_letter(pend_reg) != CY_NONE) begin
                        step_code[step_cnt] = flush_letter(pend_reg);
                        step_cnt            = step_cnt + RES_W'(1);
                    end
                    if (pend_reg == P_SHC) begin
                        step_code[step_cnt] = CY_TSE;
                        step_cnt            = step_cnt + RES_W'(1);
                    end
                    if (lone != CY_NONE) begin
                        step_code[step_cnt] = lone;
                        step_cnt            = step_cnt + RES_W'(1);
                    end else if (start_p != P_NONE) begin
                        trail = start_p;
                    end else begin
                        step_code[step_cnt] = CY_SPACE;
                        step_cnt            = step_cnt + RES_W'(1);
                    end
                end

                // end of string flushes what is still pending
                if (in_eos_reg) begin
                    if (flush_letter(trail) != CY_NONE) begin
                        step_code[step_cnt] = flush_letter(trail);
                        step_cnt            = step_cnt + RES_W'(1);
                    end
                    if (trail == P_SHC) begin
                        step_code[step_cnt] = CY_TSE;
                        step_cnt            = step_cnt + RES_W'(1);
                    end
                    pend_next = P_NONE;
                end else begin
                    pend_next = trail;
                end
            end
        end
    end

    // Translation state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= P_NONE;
            disc_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            disc_reg <= disc_next;
        end
    end

    // Result queue: up to three writes, one read per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(step_cnt);
            count_reg  <= count_after_pop + CNT_W'(step_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (RES_W'(i) < step_cnt) begin
                fifo_reg[wr_ptr_reg + PTR_W'(i)] <= '{
                    code: step_code[i],
                    err:  step_err,
                    eor:  step_err || (in_eos_reg && RES_W'(i + 1) == step_cnt)
                };
            end
        end
    end

    // Output side
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(16 - CODE_W){1'b0}}, fifo_reg[rd_ptr_reg].code};
    assign m_tuser  = fifo_reg[rd_ptr_reg].err;
    assign m_tlast  = fifo_reg[rd_ptr_reg].eor;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_err_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 16'h0000)
        else $error("error result not a bare end of run");

    a_disc_no_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        disc_reg |-> pend_reg == P_NONE)
        else $error("prefix held while discarding");

    a_disc_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && disc_reg && !pop |=> count_reg == $past(count_reg))
        else $error("result queued while discarding");

endmodule

`default_nettype wire
